### hw/rtl/i2c_trf_pkg.sv
package i2c_trf_pkg;

    // status decoding
    localparam logic [7:0] STATUS_MASK   = 8'h2D;
    localparam logic [7:0] ST_WR_ADDR    = 8'h09;
    localparam logic [7:0] ST_WR_DATA    = 8'h29;
    localparam logic [7:0] RD_FIRST_MASK = 8'h2C;
    localparam logic [7:0] ST_RD_FIRST   = 8'h0C;
    localparam logic [7:0] ST_RD_NEXT    = 8'h2C;
    localparam logic [7:0] RD_END_MASK   = 8'h28;
    localparam logic [7:0] ST_RD_END     = 8'h28;

    // byte returned for a read beyond the register file
    localparam logic [7:0] OUT_OF_RANGE_BYTE = 8'hFF;

    // command queue geometry
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [2:0] {
        EV_WR_ADDR  = 3'd0,
        EV_WR_DATA  = 3'd1,
        EV_RD_FIRST = 3'd2,
        EV_RD_NEXT  = 3'd3,
        EV_RD_END   = 3'd4,
        EV_ERROR    = 3'd5
    } t_event_class;

    // classified bus event as held in the queue
    typedef struct packed {
        t_event_class cls;
        logic [7:0]   rx_byte;
    } t_item;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_back_state;

endpackage

### hw/rtl/i2c_trf_front.sv
module i2c_trf_front (
    input  logic               i_start,
    input  logic               i_full,
    input  logic [7:0]         i_bus_status,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_clock_released,
    output logic               o_push,
    output i2c_trf_pkg::t_item o_item
);

    logic [7:0]                s;
    i2c_trf_pkg::t_event_class cls;

    assign s = i_bus_status & i2c_trf_pkg::STATUS_MASK;

    // classify the masked status, first match wins
    always_comb begin
        priority if (s == i2c_trf_pkg::ST_WR_ADDR) begin
            cls = i2c_trf_pkg::EV_WR_ADDR;
        end else if (s == i2c_trf_pkg::ST_WR_DATA) begin
            cls = i2c_trf_pkg::EV_WR_DATA;
        end else if ((s & i2c_trf_pkg::RD_FIRST_MASK) == i2c_trf_pkg::ST_RD_FIRST) begin
            cls = i2c_trf_pkg::EV_RD_FIRST;
        end else if (s == i2c_trf_pkg::ST_RD_NEXT && !i_clock_released) begin
            cls = i2c_trf_pkg::EV_RD_NEXT;
        end else if ((s & i2c_trf_pkg::RD_END_MASK) == i2c_trf_pkg::ST_RD_END) begin
            cls = i2c_trf_pkg::EV_RD_END;
        end else begin
            cls = i2c_trf_pkg::EV_ERROR;
        end
    end

    // transfer into the queue
    assign o_push          = i_start && !i_full;
    assign o_item.cls      = cls;
    assign o_item.rx_byte  = i_rx_byte;

endmodule

### hw/rtl/i2c_trf_queue.sv
module i2c_trf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2c_trf_pkg::t_item i_item,
    input  logic               i_pop,
    output i2c_trf_pkg::t_item o_item,
    output logic               o_empty,
    output logic               o_full
);

    localparam int CW = i2c_trf_pkg::QUEUE_AW + 1;

    i2c_trf_pkg::t_item                 r_mem [i2c_trf_pkg::QUEUE_DEPTH];
    logic [i2c_trf_pkg::QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [i2c_trf_pkg::QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]                      r_count,  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(i2c_trf_pkg::QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(i2c_trf_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### hw/rtl/i2c_trf_ram.sv
module i2c_trf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/i2c_trf_back.sv
module i2c_trf_back #(
    parameter int REG_COUNT = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  i2c_trf_pkg::t_item        i_item,
    output logic                      o_pop,
    output logic                      o_done,
    output logic [2:0]                o_event_class,
    output logic                      o_send_valid,
    output logic [7:0]                o_send_byte,
    output logic                      o_stored,
    output logic [7:0]                o_pointer_after
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    i2c_trf_pkg::t_back_state r_state, n_state;
    i2c_trf_pkg::t_item       r_item;

    logic [7:0]           r_pointer, n_pointer;
    logic                 r_expect,  n_expect;
    logic [REG_COUNT-1:0] r_written;
    logic                 r_rd_written;

    logic                 r_done;
    logic [2:0]           r_class;
    logic                 r_send_valid, n_send_valid;
    logic [7:0]           r_send_byte,  n_send_byte;
    logic                 r_stored,     n_stored;
    logic [7:0]           r_pointer_after;

    logic [IDX_W-1:0]     idx;
    logic                 in_range;
    logic [7:0]           ram_q;
    logic [7:0]           rd_value;
    logic                 ram_we;
    logic                 exec;

    assign idx      = r_pointer[IDX_W-1:0];
    assign in_range = ({1'b0, r_pointer} < 9'(REG_COUNT));
    assign rd_value = r_rd_written ? ram_q : 8'h00;
    assign exec     = (r_state == i2c_trf_pkg::BK_EXEC);

    i2c_trf_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (r_item.rx_byte),
        .i_raddr (idx),
        .o_rdata (ram_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i2c_trf_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = i2c_trf_pkg::BK_EXEC;
                end
            end
            i2c_trf_pkg::BK_EXEC: begin
                n_state = i2c_trf_pkg::BK_IDLE;
            end
            default: n_state = i2c_trf_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop = 1'b0;
        unique case (r_state)
            i2c_trf_pkg::BK_IDLE: o_pop = !i_empty;
            i2c_trf_pkg::BK_EXEC: o_pop = 1'b0;
            default:              o_pop = 1'b0;
        endcase
    end

    // carry out the event once the register read is back
    always_comb begin
        n_pointer    = r_pointer;
        n_expect     = r_expect;
        n_send_valid = 1'b0;
        n_send_byte  = 8'h00;
        n_stored     = 1'b0;
        ram_we       = 1'b0;
        unique case (r_item.cls)
            i2c_trf_pkg::EV_WR_ADDR: begin
                n_expect = 1'b1;
            end
            i2c_trf_pkg::EV_WR_DATA: begin
                if (r_expect) begin
                    n_expect  = 1'b0;
                    n_pointer = r_item.rx_byte;
                end else if (in_range) begin
                    ram_we    = exec;
                    n_pointer = r_pointer + 8'd1;
                    n_stored  = 1'b1;
                end
            end
            i2c_trf_pkg::EV_RD_FIRST, i2c_trf_pkg::EV_RD_NEXT: begin
                n_send_valid = 1'b1;
                if (in_range) begin
                    n_send_byte = rd_value;
                    n_pointer   = r_pointer + 8'd1;
                end else begin
                    n_send_byte = i2c_trf_pkg::OUT_OF_RANGE_BYTE;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= i2c_trf_pkg::BK_IDLE;
            r_pointer <= '0;
            r_expect  <= 1'b0;
            r_written <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= exec;
            if (exec) begin
                r_pointer <= n_pointer;
                r_expect  <= n_expect;
            end
            if (ram_we) begin
                r_written[idx] <= 1'b1;
            end
        end
    end

    // item capture, written flag of the entry being read, result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item       <= i_item;
            r_rd_written <= r_written[idx];
        end
        if (exec) begin
            r_class         <= r_item.cls;
            r_send_valid    <= n_send_valid;
            r_send_byte     <= n_send_byte;
            r_stored        <= n_stored;
            r_pointer_after <= n_pointer;
        end
    end

    assign o_done          = r_done;
    assign o_event_class   = r_class;
    assign o_send_valid    = r_send_valid;
    assign o_send_byte     = r_send_byte;
    assign o_stored        = r_stored;
    assign o_pointer_after = r_pointer_after;

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_done)
        else $error("executed event without result strobe");

    a_stored_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_stored) |-> (r_class == i2c_trf_pkg::EV_WR_DATA))
        else $error("store reported for a non-write event");

    a_send_byte_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_send_valid) |-> (r_send_byte == 8'h00))
        else $error("send byte not zero without send");

endmodule

### hw/rtl/i2c_target_register_file_unit.sv
// I2C target register file: one bus event is taken per transfer (start high while busy
// is low), classified at once and queued in a two-entry command queue; busy is high only
// while that queue is full. The execution unit takes one event at a time, through a
// registered register-file read and then the pointer and file update, so it takes no
// new event before it is through with the last, and registers each result. Each result is
// shown for exactly one cycle with o_done high and cannot be held off by the receiver.
// The register file reads as zero after reset through per-entry written flags, so there
// is no clearing pass.
module i2c_target_register_file_unit #(
    parameter int REG_COUNT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_bus_status,
    input  logic [7:0] i_rx_byte,
    input  logic       i_clock_released,
    output logic       o_done,
    output logic [2:0] o_event_class,
    output logic       o_send_valid,
    output logic [7:0] o_send_byte,
    output logic       o_stored,
    output logic [7:0] o_pointer_after
);

    i2c_trf_pkg::t_item push_item;
    i2c_trf_pkg::t_item head_item;
    logic               push;
    logic               pop;
    logic               q_empty;
    logic               q_full;

    assign busy = q_full;

    i2c_trf_front u_front (
        .i_start          (start),
        .i_full           (q_full),
        .i_bus_status     (i_bus_status),
        .i_rx_byte        (i_rx_byte),
        .i_clock_released (i_clock_released),
        .o_push           (push),
        .o_item           (push_item)
    );

    i2c_trf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    i2c_trf_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_item          (head_item),
        .o_pop           (pop),
        .o_done          (o_done),
        .o_event_class   (o_event_class),
        .o_send_valid    (o_send_valid),
        .o_send_byte     (o_send_byte),
        .o_stored        (o_stored),
        .o_pointer_after (o_pointer_after)
    );

endmodule

### bench/i2c_trf_checker.sv
`timescale 1ns / 1ps

// watches the event and result channels, predicts each result and compares in order
module i2c_trf_checker #(
    parameter int REG_COUNT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [7:0] i_bus_status,
    input  logic [7:0] i_rx_byte,
    input  logic       i_clock_released,
    input  logic       i_done,
    input  logic [2:0] i_event_class,
    input  logic       i_send_valid,
    input  logic [7:0] i_send_byte,
    input  logic       i_stored,
    input  logic [7:0] i_pointer_after,
    output int         o_checked,
    output int         o_failures,
    output int         o_pending,
    output int         o_stored,
    output int         o_out_of_range
);

    typedef struct packed {
        i2c_trf_pkg::t_event_class cls;
        logic                      send_valid;
        logic [7:0]                send_byte;
        logic                      stored;
        logic [7:0]                pointer_after;
    } t_outcome;

    // shadow of the target's state
    logic [7:0] shadow_regs [REG_COUNT];
    logic [7:0] shadow_ptr;
    logic       shadow_want_ptr;

    t_outcome pending_outcomes [$];

    // read at the pointer and advance it, or the filler byte beyond the file
    function automatic logic [7:0] fetch_register();
        logic [7:0] value;
        if (int'(shadow_ptr) < REG_COUNT) begin
            value = shadow_regs[shadow_ptr];
            shadow_ptr = shadow_ptr + 8'd1;
        end else begin
            value = i2c_trf_pkg::OUT_OF_RANGE_BYTE;
            o_out_of_range++;
        end
        return value;
    endfunction

    // classify one bus event and apply it to the shadow state
    function automatic t_outcome bus_event_outcome(input logic [7:0] status,
                                                   input logic [7:0] rx,
                                                   input logic released);
        t_outcome   res;
        logic [7:0] s;
        s = status & i2c_trf_pkg::STATUS_MASK;
        res = '0;
        if (s == i2c_trf_pkg::ST_WR_ADDR) begin
            res.cls = i2c_trf_pkg::EV_WR_ADDR;
            shadow_want_ptr = 1'b1;
        end else if (s == i2c_trf_pkg::ST_WR_DATA) begin
            res.cls = i2c_trf_pkg::EV_WR_DATA;
            if (shadow_want_ptr) begin
                shadow_want_ptr = 1'b0;
                shadow_ptr = rx;
            end else if (int'(shadow_ptr) < REG_COUNT) begin
                shadow_regs[shadow_ptr] = rx;
                shadow_ptr = shadow_ptr + 8'd1;
                res.stored = 1'b1;
                o_stored++;
            end
        end else if ((s & i2c_trf_pkg::RD_FIRST_MASK) == i2c_trf_pkg::ST_RD_FIRST) begin
            res.cls = i2c_trf_pkg::EV_RD_FIRST;
            res.send_byte = fetch_register();
            res.send_valid = 1'b1;
        end else if (s == i2c_trf_pkg::ST_RD_NEXT && !released) begin
            res.cls = i2c_trf_pkg::EV_RD_NEXT;
            res.send_byte = fetch_register();
            res.send_valid = 1'b1;
        end else if ((s & i2c_trf_pkg::RD_END_MASK) == i2c_trf_pkg::ST_RD_END) begin
            res.cls = i2c_trf_pkg::EV_RD_END;
        end else begin
            res.cls = i2c_trf_pkg::EV_ERROR;
        end
        res.pointer_after = shadow_ptr;
        return res;
    endfunction

    // results are checked before the new transfer is queued
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            foreach (shadow_regs[k]) shadow_regs[k] = 8'h00;
            shadow_ptr = 8'h00;
            shadow_want_ptr = 1'b0;
            pending_outcomes.delete();
            o_checked = 0;
            o_failures = 0;
            o_stored = 0;
            o_out_of_range = 0;
            o_pending = 0;
        end else begin
            if (i_done) begin
                got = {i2c_trf_pkg::t_event_class'(i_event_class), i_send_valid,
                       i_send_byte, i_stored, i_pointer_after};
                if (pending_outcomes.size() == 0) begin
                    if (o_failures < 10)
                        $display({"%0t: result with nothing expected: ",
                                  "cls=%0d send=%0b/%02h st=%0b ptr=%02h"},
                                 $realtime, i_event_class, i_send_valid, i_send_byte,
                                 i_stored, i_pointer_after);
                    o_failures++;
                end else begin
                    want = pending_outcomes.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        if (o_failures < 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, o_checked);
                            $display("    expected cls=%0d send=%0b/%02h st=%0b ptr=%02h",
                                     want.cls, want.send_valid, want.send_byte,
                                     want.stored, want.pointer_after);
                            $display("    actual   cls=%0d send=%0b/%02h st=%0b ptr=%02h",
                                     i_event_class, i_send_valid, i_send_byte,
                                     i_stored, i_pointer_after);
                        end
                        o_failures++;
                    end
                end
            end
            if (i_start && !i_busy)
                pending_outcomes.push_back(
                    bus_event_outcome(i_bus_status, i_rx_byte, i_clock_released));
            o_pending = pending_outcomes.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int REGS        = 32;
    localparam int EVENT_COUNT = 2000;
    localparam int CYCLE_LIMIT = 400000;

    // status codes beyond the package constants: one decodes as an error, one as a read end
    localparam logic [7:0] ST_ERROR       = 8'h00;
    localparam logic [7:0] ST_RD_END_FULL = 8'h2D;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_bus_status = 8'h00;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_clock_released = 1'b0;
    logic       o_done;
    logic [2:0] o_event_class;
    logic       o_send_valid;
    logic [7:0] o_send_byte;
    logic       o_stored;
    logic [7:0] o_pointer_after;

    int n_checked, n_failures, n_pending, n_stored, n_out_of_range;
    int events_sent;
    int cycle_count = 0;
    bit no_gaps;

    i2c_target_register_file_unit #(
        .REG_COUNT(REGS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_bus_status    (i_bus_status),
        .i_rx_byte       (i_rx_byte),
        .i_clock_released(i_clock_released),
        .o_done          (o_done),
        .o_event_class   (o_event_class),
        .o_send_valid    (o_send_valid),
        .o_send_byte     (o_send_byte),
        .o_stored        (o_stored),
        .o_pointer_after (o_pointer_after)
    );

    i2c_trf_checker #(
        .REG_COUNT(REGS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_bus_status    (i_bus_status),
        .i_rx_byte       (i_rx_byte),
        .i_clock_released(i_clock_released),
        .i_done          (o_done),
        .i_event_class   (o_event_class),
        .i_send_valid    (o_send_valid),
        .i_send_byte     (o_send_byte),
        .i_stored        (o_stored),
        .i_pointer_after (o_pointer_after),
        .o_checked       (n_checked),
        .o_failures      (n_failures),
        .o_pending       (n_pending),
        .o_stored        (n_stored),
        .o_out_of_range  (n_out_of_range)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, n_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // present one bus event and hold it until the transfer
    task automatic drive_event(input logic [7:0] status, input logic [7:0] rx,
                               input logic released);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_bus_status <= status;
        i_rx_byte <= rx;
        i_clock_released <= released;
        do @(posedge i_clk); while (busy);
        events_sent++;
    endtask

    // decoded status code with the ignored bits scrambled
    task automatic send_code(input logic [7:0] code, input logic [7:0] rx,
                             input logic released);
        drive_event((code & i2c_trf_pkg::STATUS_MASK)
                        | (8'($urandom) & ~i2c_trf_pkg::STATUS_MASK),
                    rx, released);
    endtask

    task automatic write_transaction(input logic [7:0] ptr, input int n_data);
        send_code(i2c_trf_pkg::ST_WR_ADDR, 8'($urandom), 1'($urandom));
        send_code(i2c_trf_pkg::ST_WR_DATA, ptr, 1'($urandom));
        repeat (n_data) send_code(i2c_trf_pkg::ST_WR_DATA, 8'($urandom), 1'($urandom));
    endtask

    task automatic read_transaction(input logic [7:0] ptr, input int n_reads);
        write_transaction(ptr, 0);
        send_code(i2c_trf_pkg::ST_RD_FIRST | 8'($urandom_range(0, 1)), 8'($urandom),
                  1'($urandom));
        repeat (n_reads - 1) send_code(i2c_trf_pkg::ST_RD_NEXT, 8'($urandom), 1'b0);
        if ($urandom_range(0, 1))
            send_code(i2c_trf_pkg::ST_RD_NEXT, 8'($urandom), 1'b1);
        else
            send_code($urandom_range(0, 1) ? i2c_trf_pkg::ST_RD_END : ST_RD_END_FULL,
                      8'($urandom), 1'($urandom));
    endtask

    function automatic logic [7:0] random_pointer();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, REGS + 2));
        return 8'($urandom);
    endfunction

    // stimulus and verdict
    initial begin
        int pick;
        events_sent = 0;
        no_gaps = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset contents, field extremes, range edges and every class
        send_code(i2c_trf_pkg::ST_RD_FIRST, 8'h00, 1'b0);
        send_code(i2c_trf_pkg::ST_RD_NEXT, 8'hFF, 1'b0);
        drive_event(8'h00, 8'h00, 1'b0);
        drive_event(8'hFF, 8'hFF, 1'b1);
        write_transaction(8'h00, 2);
        send_code(i2c_trf_pkg::ST_WR_DATA, 8'hFF, 1'b0);
        write_transaction(8'(REGS - 1), 2);
        read_transaction(8'(REGS - 2), 3);
        write_transaction(8'hFF, 1);
        send_code(i2c_trf_pkg::ST_RD_FIRST, 8'h00, 1'b1);
        send_code(i2c_trf_pkg::ST_RD_NEXT, 8'h00, 1'b1);
        send_code(ST_ERROR, 8'h5A, 1'b0);
        read_transaction(8'h00, 2);

        // random: mostly well-formed transactions, some noise and broken sequences
        while (events_sent < EVENT_COUNT) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                write_transaction(random_pointer(), $urandom_range(0, 6));
            else if (pick < 8)
                read_transaction(random_pointer(), $urandom_range(1, 6));
            else
                repeat ($urandom_range(1, 4))
                    drive_event(8'($urandom), 8'($urandom), 1'($urandom));
        end
        start <= 1'b0;

        // drain
        while (n_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d bus events sent, %0d results checked", events_sent, n_checked);
        $display("%0d bytes stored, %0d reads beyond the register file",
                 n_stored, n_out_of_range);
        if (n_failures == 0 && n_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/i2c_trf_pkg.sv
hw/rtl/i2c_trf_front.sv
hw/rtl/i2c_trf_queue.sv
hw/rtl/i2c_trf_ram.sv
hw/rtl/i2c_trf_back.sv
hw/rtl/i2c_target_register_file_unit.sv
bench/i2c_trf_checker.sv
bench/testbench.sv
